// File: hw/rtl/door_motor_limit_switch_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Door motor controller assertion macros
// Shared concurrent assertion forms for the door motor controller RTL.
// ----------------------------------------------------------------------------
`ifndef DOOR_MOTOR_LIMIT_SWITCH_CONTROLLER_CORE_ASSERT_SVH
`define DOOR_MOTOR_LIMIT_SWITCH_CONTROLLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DMLSC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

`define DMLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define DMLSC_ASSERT_SAME(label, clk, rst, ante, cons)

`define DMLSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/dmlsc_pkg.sv
// ----------------------------------------------------------------------------
// Door motor controller package
// Types, codes, register defaults and the switch decoder.
// ----------------------------------------------------------------------------
package dmlsc_pkg;

  localparam int TICK_COUNT_WIDTH_DEF = 12;
  localparam int ALIGN_W = 8;
  localparam int LAG_W = 8;
  localparam int TIMEOUT_W = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 8'd3;
  localparam logic [LAG_W-1:0] LAG_RESET = 8'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd60;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_OPEN   = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_STATUS = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    POS_UNDEF  = 3'd0,
    POS_OPEN   = 3'd1,
    POS_CLOSED = 3'd2,
    POS_MIDDLE = 3'd3,
    POS_FAULT  = 3'd4
  } pos_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ALIGN   = 2'd0,
    CFG_LAG     = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ALIGN_W-1:0]   align_ticks;
    logic [LAG_W-1:0]     lag_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic       open_limit_level;
    logic       closed_limit_level;
  } item_t;

  typedef struct packed {
    logic       relay_open;
    logic       relay_close;
    logic       led_open;
    logic       led_closed;
    logic [2:0] position;
    logic       busy_res;
    logic       move_done;
    logic       timed_out;
    logic       rejected;
  } res_t;

  typedef struct packed {
    pos_t       pos;
    logic [1:0] lamps;
  } decode_t;

  // Lamp bit 0 is the open lamp, bit 1 the closed lamp.
  function automatic decode_t decode_position(logic op, logic cl);
    decode_t d;
    case ({op, cl})
      2'b01: begin
        d.pos = POS_OPEN;
        d.lamps = 2'b01;
      end
      2'b10: begin
        d.pos = POS_CLOSED;
        d.lamps = 2'b10;
      end
      2'b11: begin
        d.pos = POS_MIDDLE;
        d.lamps = 2'b00;
      end
      default: begin
        d.pos = POS_FAULT;
        d.lamps = 2'b11;
      end
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/door_motor_limit_switch_controller_core.sv
// ----------------------------------------------------------------------------
// Door motor controller core
// Two-relay door motor control with active-low limit switches.
// ----------------------------------------------------------------------------
// Channel   Signals                                     Handshake
// in        func, open_limit_level, closed_limit_level  in_valid / in_stall
// out       relay_open .. rejected                      out_valid / out_stall
// cfg       cfg_index, cfg_data                         cfg_valid / cfg_ready
//
// Each request passes an input register and a result register, one request per
// cycle when the output is not stalled.
// The move state updates as a request moves from the input register to the
// result register, so a new request may enter every cycle.
// A stalled result holds the result register; the input register then fills
// and in_stall rises. Reset clears both stages and loads register defaults.
// ----------------------------------------------------------------------------
module door_motor_limit_switch_controller_core import dmlsc_pkg::*; #(
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic                   open_limit_level,
  input  logic                   closed_limit_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   relay_open,
  output logic                   relay_close,
  output logic                   led_open,
  output logic                   led_closed,
  output logic [2:0]             position,
  output logic                   busy_res,
  output logic                   move_done,
  output logic                   timed_out,
  output logic                   rejected,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  in_valid_q;
  item_t item_q;
  logic  advance;
  res_t  res;
  res_t  res_q;

  assign advance = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q.func <= func;
      item_q.open_limit_level <= open_limit_level;
      item_q.closed_limit_level <= closed_limit_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  dmlsc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmlsc_ctrl #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  assign relay_open = res_q.relay_open;
  assign relay_close = res_q.relay_close;
  assign led_open = res_q.led_open;
  assign led_closed = res_q.led_closed;
  assign position = res_q.position;
  assign busy_res = res_q.busy_res;
  assign move_done = res_q.move_done;
  assign timed_out = res_q.timed_out;
  assign rejected = res_q.rejected;

endmodule

// File: hw/rtl/dmlsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Door motor controller configuration registers
// Holds the alignment, lag and timeout settings written over the config port.
// ----------------------------------------------------------------------------
module dmlsc_cfg_regs import dmlsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.align_ticks <= ALIGN_RESET;
      cfg.lag_ticks <= LAG_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALIGN:   cfg.align_ticks <= cfg_data[ALIGN_W-1:0];
        CFG_LAG:     cfg.lag_ticks <= cfg_data[LAG_W-1:0];
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dmlsc_ctrl.sv
// ----------------------------------------------------------------------------
// Door motor controller move control
// Move state registers and the per-request update that produces one result.
// ----------------------------------------------------------------------------
`include "door_motor_limit_switch_controller_core_assert.svh"

module dmlsc_ctrl import dmlsc_pkg::*; #(
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CMP_W = (TICK_COUNT_WIDTH > TIMEOUT_W) ? TICK_COUNT_WIDTH : TIMEOUT_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({TICK_COUNT_WIDTH{1'b1}});

  logic                        moving;
  logic                        moving_next;
  dir_t                        direction;
  dir_t                        direction_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count;
  logic [TICK_COUNT_WIDTH-1:0] tick_count_next;
  logic [ALIGN_W-1:0]          align_count;
  logic [ALIGN_W-1:0]          align_count_next;
  pos_t                        stored_position;
  pos_t                        stored_position_next;
  logic [1:0]                  lamp_levels;
  logic [1:0]                  lamp_levels_next;

  func_t                       func_e;
  decode_t                     dec;
  logic [CMP_W-1:0]            timeout_ext;
  logic [CMP_W-1:0]            limit;
  logic [TICK_COUNT_WIDTH-1:0] tick_inc;
  logic                        at_limit;
  logic                        inc_at_limit;
  logic                        past_lag;
  logic                        align_reached;
  logic                        active;
  logic                        end_move;
  logic                        tmo;
  pos_t                        pos;
  logic                        dir_running;
  logic                        busy_command;

  assign func_e = func_t'(item.func);
  assign dec = decode_position(item.open_limit_level, item.closed_limit_level);
  assign timeout_ext = CMP_W'(cfg.timeout_ticks);
  assign limit = (timeout_ext < COUNT_MAX) ? timeout_ext : COUNT_MAX;
  assign tick_inc = tick_count + 1'b1;
  assign at_limit = CMP_W'(tick_count) >= limit;
  assign inc_at_limit = CMP_W'(tick_inc) >= limit;
  assign past_lag = CMP_W'(tick_count) >= CMP_W'(cfg.lag_ticks);
  assign align_reached = align_count >= cfg.align_ticks;
  assign active = (direction == DIR_CLOSE) ? !item.closed_limit_level
                                           : !item.open_limit_level;
  assign dir_running = (direction == DIR_OPEN) || (direction == DIR_CLOSE);
  assign busy_command = step && moving && ((func_e == FUNC_OPEN) || (func_e == FUNC_CLOSE));

  always_comb begin
    moving_next = moving;
    direction_next = direction;
    tick_count_next = tick_count;
    align_count_next = align_count;
    stored_position_next = stored_position;
    lamp_levels_next = lamp_levels;
    pos = stored_position;
    end_move = 1'b0;
    tmo = 1'b0;
    res.rejected = 1'b0;
    case (func_e)
      FUNC_TICK: begin
        if (moving) begin
          if (at_limit) begin
            end_move = 1'b1;
            tmo = 1'b1;
          end else begin
            if (active && align_reached) begin
              end_move = 1'b1;
            end else if (active && past_lag) begin
              align_count_next = align_count + 1'b1;
            end
            tick_count_next = tick_inc;
            if (inc_at_limit) begin
              end_move = 1'b1;
            end
            tmo = inc_at_limit;
          end
          if (end_move) begin
            moving_next = 1'b0;
            direction_next = DIR_STOP;
            stored_position_next = dec.pos;
            lamp_levels_next = dec.lamps;
            pos = dec.pos;
          end
        end
      end
      FUNC_STATUS: begin
        pos = dec.pos;
        lamp_levels_next = dec.lamps;
      end
      FUNC_OPEN, FUNC_CLOSE: begin
        if (moving) begin
          res.rejected = 1'b1;
        end else begin
          if (func_e == FUNC_CLOSE && stored_position == POS_OPEN) begin
            direction_next = DIR_CLOSE;
          end else begin
            direction_next = DIR_OPEN;
          end
          moving_next = 1'b1;
          tick_count_next = '0;
          align_count_next = '0;
        end
      end
      default: begin
      end
    endcase
    res.relay_open = moving_next && (direction_next == DIR_OPEN);
    res.relay_close = moving_next && (direction_next == DIR_CLOSE);
    res.led_open = lamp_levels_next[0];
    res.led_closed = lamp_levels_next[1];
    res.position = pos;
    res.busy_res = moving_next;
    res.move_done = end_move;
    res.timed_out = end_move && tmo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving <= 1'b0;
      direction <= DIR_STOP;
      tick_count <= '0;
      align_count <= '0;
      stored_position <= POS_UNDEF;
      lamp_levels <= 2'b00;
    end else if (step) begin
      moving <= moving_next;
      direction <= direction_next;
      tick_count <= tick_count_next;
      align_count <= align_count_next;
      stored_position <= stored_position_next;
      lamp_levels <= lamp_levels_next;
    end
  end

  `DMLSC_ASSERT_SAME(a_dir_set_when_moving, clk, rst, moving, dir_running)
  `DMLSC_ASSERT_SAME(a_dir_clear_when_idle, clk, rst, !moving, direction == DIR_STOP)
  `DMLSC_ASSERT_NEXT(a_done_stops_motor, clk, rst, step && res.move_done, !moving)
  `DMLSC_ASSERT_SAME(a_busy_command_rejected, clk, rst, busy_command, res.rejected && !res.move_done)

endmodule

// File: dv/door_motor_limit_switch_controller_core_tb.sv
// ----------------------------------------------------------------------------
// Door motor controller core testbench
// A queue-fed driver sends door events: ticks, open and close commands, and
// status queries. A clocked monitor checks each result, field by field,
// against a cycle-free model of the move, alignment, timeout and position
// logic. The register settings include the extremes, a zero timeout, and a
// timeout lowered during a move. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module door_motor_limit_switch_controller_core_tb import dmlsc_pkg::*; ();

  localparam int TICK_MAX = (1 << TICK_COUNT_WIDTH_DEF) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_LIMIT = 200;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             func;
  logic                   open_limit_level;
  logic                   closed_limit_level;
  logic                   out_valid;
  logic                   out_stall;
  logic                   relay_open;
  logic                   relay_close;
  logic                   led_open;
  logic                   led_closed;
  logic [2:0]             position;
  logic                   busy_res;
  logic                   move_done;
  logic                   timed_out;
  logic                   rejected;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [ALIGN_W-1:0]   reg_align = ALIGN_RESET;
  logic [LAG_W-1:0]     reg_lag = LAG_RESET;
  logic [TIMEOUT_W-1:0] reg_timeout = TIMEOUT_RESET;

  logic         door_moving = 1'b0;
  dir_t         door_dir = DIR_STOP;
  int           door_ticks = 0;
  logic [7:0]   door_aligned = 8'd0;
  pos_t         door_pos = POS_UNDEF;
  logic [1:0]   door_lamps = 2'b00;

  item_t pending_requests[$];
  res_t  expected_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  door_motor_limit_switch_controller_core #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .open_limit_level(open_limit_level),
    .closed_limit_level(closed_limit_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .relay_open(relay_open),
    .relay_close(relay_close),
    .led_open(led_open),
    .led_closed(led_closed),
    .position(position),
    .busy_res(busy_res),
    .move_done(move_done),
    .timed_out(timed_out),
    .rejected(rejected),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Limit switches are active low.
  function automatic void decode_switches(input logic op, input logic cl,
                                          output pos_t pos, output logic [1:0] lamps);
    if (!op && cl) begin
      pos = POS_OPEN;
      lamps = 2'b01;
    end else if (op && !cl) begin
      pos = POS_CLOSED;
      lamps = 2'b10;
    end else if (op && cl) begin
      pos = POS_MIDDLE;
      lamps = 2'b00;
    end else begin
      pos = POS_FAULT;
      lamps = 2'b11;
    end
  endfunction

  function automatic res_t predict_door(item_t it);
    res_t r;
    pos_t shown;
    int limit;
    logic move_over;
    logic level;
    logic active;
    r = '0;
    shown = door_pos;
    limit = (int'(reg_timeout) < TICK_MAX) ? int'(reg_timeout) : TICK_MAX;
    case (func_t'(it.func))
      FUNC_TICK: begin
        if (door_moving) begin
          move_over = 1'b0;
          if (door_ticks >= limit) begin
            move_over = 1'b1;
          end else begin
            level = (door_dir == DIR_CLOSE) ? it.closed_limit_level : it.open_limit_level;
            active = !level;
            if (active && door_aligned >= reg_align) begin
              move_over = 1'b1;
            end else if (active && door_ticks >= int'(reg_lag)) begin
              door_aligned = door_aligned + 8'd1;
            end
            if (door_ticks < TICK_MAX) begin
              door_ticks++;
            end
            if (door_ticks >= limit) begin
              move_over = 1'b1;
            end
          end
          if (move_over) begin
            r.timed_out = (door_ticks >= limit);
            r.move_done = 1'b1;
            door_moving = 1'b0;
            door_dir = DIR_STOP;
            decode_switches(it.open_limit_level, it.closed_limit_level, door_pos, door_lamps);
            shown = door_pos;
          end
        end
      end
      FUNC_STATUS: begin
        decode_switches(it.open_limit_level, it.closed_limit_level, shown, door_lamps);
      end
      default: begin
        if (door_moving) begin
          r.rejected = 1'b1;
        end else begin
          door_dir = (func_t'(it.func) == FUNC_CLOSE && door_pos == POS_OPEN) ?
                     DIR_CLOSE : DIR_OPEN;
          door_moving = 1'b1;
          door_ticks = 0;
          door_aligned = 8'd0;
        end
      end
    endcase
    r.relay_open = door_moving && door_dir == DIR_OPEN;
    r.relay_close = door_moving && door_dir == DIR_CLOSE;
    r.led_open = door_lamps[0];
    r.led_closed = door_lamps[1];
    r.position = shown;
    r.busy_res = door_moving;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic string field_diff(string name, logic [2:0] got, logic [2:0] want);
    return (got !== want) ? $sformatf(" %s %0d/%0d", name, got, want) : "";
  endfunction

  always @(posedge clk) begin : feed_requests
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_door(pending_requests.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          func <= pending_requests[0].func;
          open_limit_level <= pending_requests[0].open_limit_level;
          closed_limit_level <= pending_requests[0].closed_limit_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    string diffs;
    if (!rst) begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
        end else begin
          want = expected_results.pop_front();
          diffs = {field_diff("relay_open", relay_open, want.relay_open),
                   field_diff("relay_close", relay_close, want.relay_close),
                   field_diff("led_open", led_open, want.led_open),
                   field_diff("led_closed", led_closed, want.led_closed),
                   field_diff("position", position, want.position),
                   field_diff("busy_res", busy_res, want.busy_res),
                   field_diff("move_done", move_done, want.move_done),
                   field_diff("timed_out", timed_out, want.timed_out),
                   field_diff("rejected", rejected, want.rejected)};
          if (diffs != "") begin
            report_mismatch($sformatf("result %0d (got/expected):%s", results_seen, diffs));
          end
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("door_motor_limit_switch_controller_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_event(func_t f, logic op, logic cl);
    item_t it;
    it.func = f;
    it.open_limit_level = op;
    it.closed_limit_level = cl;
    pending_requests.push_back(it);
  endtask

  // A command, then the door approaching and settling on the far switch.
  task automatic queue_move(ref int left);
    func_t cmd;
    int approach;
    int settle;
    logic to_closed;
    logic op;
    logic cl;
    cmd = ($urandom_range(0, 1) != 0) ? FUNC_CLOSE : FUNC_OPEN;
    to_closed = (cmd == FUNC_CLOSE);
    queue_event(cmd, 1'($urandom), 1'($urandom));
    left--;
    approach = $urandom_range(0, 6);
    settle = int'(reg_lag) + int'(reg_align) + $urandom_range(0, 4);
    for (int i = 0; i < approach + settle && left > 0; i++) begin
      op = 1'b1;
      cl = 1'b1;
      if (i >= approach) begin
        if (to_closed) begin
          cl = 1'b0;
        end else begin
          op = 1'b0;
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) != 0) begin
          op = !op;
        end else begin
          cl = !cl;
        end
      end
      if ($urandom_range(0, 14) == 0) begin
        queue_event(FUNC_STATUS, 1'($urandom), 1'($urandom));
        left--;
      end else if ($urandom_range(0, 24) == 0) begin
        queue_event(($urandom_range(0, 1) != 0) ? FUNC_OPEN : FUNC_CLOSE,
                    1'($urandom), 1'($urandom));
        left--;
      end
      queue_event(FUNC_TICK, op, cl);
      left--;
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALIGN: reg_align = data[ALIGN_W-1:0];
      CFG_LAG: reg_lag = data[LAG_W-1:0];
      CFG_TIMEOUT: reg_timeout = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int align, int lag, int timeout);
    write_reg(CFG_ALIGN, {4'($urandom), 8'(align)});
    write_reg(CFG_LAG, {4'($urandom), 8'(lag)});
    write_reg(CFG_TIMEOUT, 12'(timeout));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int count, bit pause_midway);
    int chunks;
    int left;
    int pick;
    chunks = pause_midway ? 2 : 1;
    for (int c = 0; c < chunks; c++) begin
      left = count / chunks;
      while (left > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          queue_move(left);
        end else if (pick < 80) begin
          queue_event(FUNC_STATUS, 1'($urandom), 1'($urandom));
          left--;
        end else if (pick < 90) begin
          queue_event(FUNC_TICK, 1'($urandom), 1'($urandom));
          left--;
        end else begin
          queue_event(func_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
          left--;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_TICK;
    open_limit_level = 1'b1;
    closed_limit_level = 1'b1;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ALIGN;
    cfg_data = '0;
    send_idle_pct = 38;
    recv_stall_pct = 78;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: an idle tick, every switch decode on a status query,
    // a close forced to open, commands rejected mid-move, then a real close.
    queue_event(FUNC_TICK, 1'b1, 1'b1);
    queue_event(FUNC_STATUS, 1'b0, 1'b1);
    queue_event(FUNC_STATUS, 1'b1, 1'b0);
    queue_event(FUNC_STATUS, 1'b1, 1'b1);
    queue_event(FUNC_STATUS, 1'b0, 1'b0);
    queue_event(FUNC_CLOSE, 1'b1, 1'b1);
    queue_event(FUNC_OPEN, 1'b1, 1'b1);
    queue_event(FUNC_CLOSE, 1'b0, 1'b0);
    queue_event(FUNC_TICK, 1'b0, 1'b1);
    queue_event(FUNC_STATUS, 1'b1, 1'b1);
    repeat (5) queue_event(FUNC_TICK, 1'b0, 1'b1);
    queue_event(FUNC_CLOSE, 1'b0, 1'b1);
    repeat (6) queue_event(FUNC_TICK, 1'b1, 1'b0);
    queue_event(FUNC_TICK, 1'b0, 1'b0);
    wait_idle();

    set_config(1, 0, 12);
    run_phase(200, 1'b0);
    write_reg(CFG_UNMAPPED, 12'($urandom));
    set_config(0, 0, 4095);
    run_phase(150, 1'b0);

    send_idle_pct = 78;
    recv_stall_pct = 38;
    set_config(255, 255, 4095);
    run_phase(100, 1'b0);
    set_config(4, 3, 0);
    run_phase(150, 1'b0);
    set_config(3, 10, 30);
    run_phase(200, 1'b1);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(2, 1, 1);
    run_phase(150, 1'b0);
    set_config($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(1, 40));
    run_phase(300, 1'b0);

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("door_motor_limit_switch_controller_core_tb: PASS");
    end else begin
      $display("door_motor_limit_switch_controller_core_tb: FAIL");
    end
    $finish;
  end

endmodule
